// File: hdl/assert_macros.svh
// assertion helpers used by the angle pid rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is active
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/apid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apid_pkg
// Shared widths, constants, codes and helper functions of the angle pid.
// ----------------------------------------------------------------------------
package apid_pkg;

  // fixed point format
  localparam int FracBits = 16;
  localparam int DataW    = 32;
  // raw error with wrap offsets, wide enough at this fraction width
  localparam int ErrW     = 35;
  // product after the fraction shift
  localparam int TermW    = 2 * DataW - FracBits;
  // sum of three terms
  localparam int SumW     = TermW + 2;
  // integral accumulator on the separated path
  localparam int IntW     = DataW + 2;
  // separation test operands
  localparam int SepW     = 38;
  localparam int CfgIdxW  = 3;

  localparam logic signed [ErrW-1:0] HalfTurn = ErrW'(180) <<< FracBits;
  localparam logic signed [ErrW-1:0] FullTurn = ErrW'(360) <<< FracBits;
  localparam logic signed [IntW-1:0] IntLimit = IntW'(50) <<< FracBits;

  localparam logic signed [63:0] Max32 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Min32 = 64'shFFFF_FFFF_8000_0000;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgKp     = 3'd0,
    CfgKi     = 3'd1,
    CfgKd     = 3'd2,
    CfgKiRecp = 3'd3,
    CfgMin    = 3'd4,
    CfgMax    = 3'd5,
    CfgSepLim = 3'd6
  } cfg_idx_e;

  // multiplier operand pair
  typedef enum logic [1:0] {
    MulKp   = 2'd0,
    MulKi   = 2'd1,
    MulKd   = 2'd2,
    MulBack = 2'd3
  } mul_sel_e;

  // step strobes from the sequencer to the datapath
  typedef struct packed {
    logic     ld_err;
    logic     ld_diff;
    logic     ld_integ;
    logic     ld_pterm;
    logic     ld_psum;
    logic     ld_sum;
    logic     ld_clamp;
    logic     ld_num;
    logic     ld_back;
    logic     fin;
    logic     mul_en;
    mul_sel_e mul_sel;
  } ctl_t;

  // saturate to the 32-bit signed range
  function automatic logic signed [DataW-1:0] sat32(input logic signed [63:0] v);
    logic signed [DataW-1:0] r;
    if (v > Max32) begin
      r = Max32[DataW-1:0];
    end else if (v < Min32) begin
      r = Min32[DataW-1:0];
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  // drop the fraction bits, floor rounding
  function automatic logic signed [TermW-1:0] frac_shift(input logic signed [63:0] p);
    return $signed(p[63:FracBits]);
  endfunction

endpackage
`default_nettype wire

// File: hdl/apid_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apid_if
// Valid/ready channels carrying one sample in and one controller result out.
// ----------------------------------------------------------------------------

// sample channel
interface apid_in_if import apid_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] target_angle;
  logic signed [DataW-1:0] measured_angle;
  logic                    clear_state;

  modport source (output valid, target_angle, measured_angle, clear_state, input ready);
  modport sink   (input valid, target_angle, measured_angle, clear_state, output ready);
endinterface

// result channel
interface apid_out_if import apid_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] drive;
  logic                    clamped;

  modport source (output valid, drive, clamped, input ready);
  modport sink   (input valid, drive, clamped, output ready);
endinterface
`default_nettype wire

// File: hdl/apid_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apid_mul
// Shared 32x32 signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module apid_mul import apid_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [DataW-1:0] a_i,
  input  wire logic signed [DataW-1:0] b_i,
  output logic signed [63:0]           prod_o
);

  logic signed [63:0] prod_q;
  logic signed [63:0] prod_d;

  // full-precision product
  assign prod_d = 64'(a_i) * 64'(b_i);

  // product register, loaded on request
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// File: hdl/apid_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apid_seq
// Step sequencer: walks one sample through error, difference, integral, the three
// multiplies, sum, output clamp and the optional back-calculation; a clear skips to the end.
// ----------------------------------------------------------------------------
module apid_seq import apid_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic clear_i,
  input  wire logic backcalc_i,
  input  wire logic out_free_i,
  output logic      ready_o,
  output ctl_t      ctl_o
);

  typedef enum logic [11:0] {
    StIdle  = 12'b0000_0000_0001,
    StErr   = 12'b0000_0000_0010,
    StDiff  = 12'b0000_0000_0100,
    StMulP  = 12'b0000_0000_1000,
    StMulI  = 12'b0000_0001_0000,
    StMulD  = 12'b0000_0010_0000,
    StSum   = 12'b0000_0100_0000,
    StClamp = 12'b0000_1000_0000,
    StNum   = 12'b0001_0000_0000,
    StBMul  = 12'b0010_0000_0000,
    StBack  = 12'b0100_0000_0000,
    StFin   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and step strobes
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    ctl_o.mul_sel = MulKp;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = clear_i ? StFin : StErr;
        end
      end
      StErr: begin
        ctl_o.ld_err = 1'b1;
        state_d = StDiff;
      end
      StDiff: begin
        ctl_o.ld_diff = 1'b1;
        state_d = StMulP;
      end
      StMulP: begin
        ctl_o.ld_integ = 1'b1;
        ctl_o.mul_en   = 1'b1;
        ctl_o.mul_sel  = MulKp;
        state_d = StMulI;
      end
      StMulI: begin
        ctl_o.ld_pterm = 1'b1;
        ctl_o.mul_en   = 1'b1;
        ctl_o.mul_sel  = MulKi;
        state_d = StMulD;
      end
      StMulD: begin
        ctl_o.ld_psum = 1'b1;
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MulKd;
        state_d = StSum;
      end
      StSum: begin
        ctl_o.ld_sum = 1'b1;
        state_d = StClamp;
      end
      StClamp: begin
        ctl_o.ld_clamp = 1'b1;
        state_d = backcalc_i ? StNum : StFin;
      end
      StNum: begin
        ctl_o.ld_num = 1'b1;
        state_d = StBMul;
      end
      StBMul: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MulBack;
        state_d = StBack;
      end
      StBack: begin
        ctl_o.ld_back = 1'b1;
        state_d = StFin;
      end
      StFin: begin
        ctl_o.fin = 1'b1;
        if (out_free_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign ready_o = (state_q == StIdle);

endmodule
`default_nettype wire

// File: hdl/angle_pid_with_anti_windup.sv
// sequencing: a new sample is taken only while the sequencer is idle, one at a time;
//   a clear request skips from idle straight to the result step
// multiplier: a single shared one takes the p, i, d and back-calc products in turn
// reset: asynchronous active low; gains, limits, integral and last error go to zero,
//   the sequencer returns to idle and the result register empties
`default_nettype none
// ----------------------------------------------------------------------------
// angle_pid_with_anti_windup
// Angle pid step in signed fixed point with error wrap, integral separation,
// output clamp and integral back-calculation on a shared multiplier.
// ----------------------------------------------------------------------------
module angle_pid_with_anti_windup import apid_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [DataW-1:0]     cfg_data_i,
  apid_in_if.sink                   in_i,
  apid_out_if.source                out_o
);

  // configuration registers
  logic signed [DataW-1:0] kp_q, ki_q, kd_q, kir_q, dmin_q, dmax_q, sep_q;

  // sample and working registers
  logic signed [DataW-1:0] tgt_q, meas_q;
  logic                    clr_q;
  logic signed [DataW-1:0] err_q, err_d;
  logic signed [DataW:0]   diff_q;
  logic signed [DataW-1:0] deriv_q;
  logic signed [DataW-1:0] integ_q, integ_d;
  logic signed [DataW-1:0] prev_q;
  logic signed [TermW-1:0] pterm_q;
  logic signed [SumW-1:0]  sum_q;
  logic signed [SumW-1:0]  pd_q;
  logic signed [DataW-1:0] drive_q, drive_d;
  logic                    clamped_q, clamped_d;
  logic signed [DataW-1:0] num_q;

  // result register
  logic                    out_valid_q;
  logic signed [DataW-1:0] out_drive_q;
  logic                    out_clamped_q;

  ctl_t                    ctl;
  logic                    in_fire;
  logic                    out_free;
  logic                    backcalc;
  logic signed [DataW-1:0] mul_a, mul_b;
  logic signed [63:0]      prod;
  logic signed [TermW-1:0] term;

  // error and separation intermediates
  logic signed [ErrW-1:0]  err_raw, err_wrap;
  logic signed [DataW:0]   abs_e;
  logic signed [DataW+1:0] diff_x, abs_d;
  logic signed [SepW-1:0]  ten_d, three_l;
  logic                    sep_ok;
  logic signed [IntW-1:0]  int_acc;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign term     = frac_shift(prod);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= '0;
      ki_q   <= '0;
      kd_q   <= '0;
      kir_q  <= '0;
      dmin_q <= '0;
      dmax_q <= '0;
      sep_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgKp:     kp_q   <= $signed(cfg_data_i);
        CfgKi:     ki_q   <= $signed(cfg_data_i);
        CfgKd:     kd_q   <= $signed(cfg_data_i);
        CfgKiRecp: kir_q  <= $signed(cfg_data_i);
        CfgMin:    dmin_q <= $signed(cfg_data_i);
        CfgMax:    dmax_q <= $signed(cfg_data_i);
        CfgSepLim: sep_q  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // sequencer
  apid_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire),
    .clear_i    (in_i.clear_state),
    .backcalc_i (backcalc),
    .out_free_i (out_free),
    .ready_o    (in_i.ready),
    .ctl_o      (ctl)
  );

  // multiplier operand select
  always_comb begin
    case (ctl.mul_sel)
      MulKp: begin
        mul_a = kp_q;
        mul_b = err_q;
      end
      MulKi: begin
        mul_a = ki_q;
        mul_b = integ_q;
      end
      MulKd: begin
        mul_a = kd_q;
        mul_b = deriv_q;
      end
      MulBack: begin
        mul_a = num_q;
        mul_b = kir_q;
      end
      default: begin
        mul_a = kp_q;
        mul_b = err_q;
      end
    endcase
  end

  apid_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctl.mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // angle error, wrapped once into a half turn and saturated
  always_comb begin
    err_raw = ErrW'(tgt_q) - ErrW'(meas_q);
    if (err_raw > HalfTurn) begin
      err_wrap = err_raw - FullTurn;
    end else if (err_raw < -HalfTurn) begin
      err_wrap = err_raw + FullTurn;
    end else begin
      err_wrap = err_raw;
    end
    err_d = sat32(64'(err_wrap));
  end

  // separation test and integral update
  always_comb begin
    abs_e   = (err_q < 0) ? -(DataW+1)'(err_q) : (DataW+1)'(err_q);
    diff_x  = (DataW+2)'(diff_q);
    abs_d   = (diff_x < 0) ? -diff_x : diff_x;
    ten_d   = (SepW'(abs_d) <<< 3) + (SepW'(abs_d) <<< 1);
    three_l = (SepW'(sep_q) <<< 1) + SepW'(sep_q);
    sep_ok  = (abs_e < (DataW+1)'(sep_q)) && (ten_d < three_l);
    int_acc = IntW'(integ_q) + (sep_ok ? IntW'(err_q) : IntW'(0));
    if (sep_q > 0) begin
      if (int_acc > IntLimit) begin
        integ_d = DataW'(IntLimit);
      end else if (int_acc < -IntLimit) begin
        integ_d = DataW'(-IntLimit);
      end else begin
        integ_d = DataW'(int_acc);
      end
    end else begin
      integ_d = sat32(64'(integ_q) + 64'(err_q));
    end
  end

  // output clamp, upper limit checked first, and back-calc decision
  always_comb begin
    if (64'(sum_q) > 64'(dmax_q)) begin
      drive_d   = dmax_q;
      clamped_d = 1'b1;
    end else if (64'(sum_q) < 64'(dmin_q)) begin
      drive_d   = dmin_q;
      clamped_d = 1'b1;
    end else begin
      drive_d   = DataW'(sum_q);
      clamped_d = 1'b0;
    end
    backcalc = clamped_d && (ki_q != 0) &&
               (((err_q > 0) && (drive_d > 0)) || ((err_q < 0) && (drive_d < 0)));
  end

  // sample capture and working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tgt_q  <= in_i.target_angle;
      meas_q <= in_i.measured_angle;
      clr_q  <= in_i.clear_state;
    end
    if (ctl.ld_err) begin
      err_q <= err_d;
    end
    if (ctl.ld_diff) begin
      diff_q <= (DataW+1)'(err_q) - (DataW+1)'(prev_q);
    end
    if (ctl.ld_integ) begin
      deriv_q <= sat32(64'(diff_q));
    end
    if (ctl.ld_pterm) begin
      pterm_q <= term;
    end
    if (ctl.ld_psum) begin
      sum_q <= SumW'(pterm_q) + SumW'(term);
    end
    if (ctl.ld_sum) begin
      sum_q <= sum_q + SumW'(term);
      pd_q  <= SumW'(pterm_q) + SumW'(term);
    end
    if (ctl.ld_clamp) begin
      drive_q   <= drive_d;
      clamped_q <= clamped_d;
    end
    if (ctl.ld_num) begin
      num_q <= sat32(64'(drive_q) - 64'(pd_q));
    end
  end

  // controller state: integral and last error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else if (ctl.fin && clr_q) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else begin
      if (ctl.ld_integ) begin
        integ_q <= integ_d;
      end else if (ctl.ld_back) begin
        integ_q <= sat32(64'(term));
      end
      if (ctl.ld_sum) begin
        prev_q <= err_q;
      end
    end
  end

  // result register, freed by an output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.fin && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.fin && out_free) begin
      out_drive_q   <= clr_q ? '0 : drive_q;
      out_clamped_q <= clr_q ? 1'b0 : clamped_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.drive   = out_drive_q;
  assign out_o.clamped = out_clamped_q;

  // checks
  `include "assert_macros.svh"

  `ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_fire, !in_i.ready)
  `ASSERT_IMP(a_clamp_at_limit, clk_i, rst_ni, out_o.valid && out_o.clamped,
              (out_o.drive == dmax_q) || (out_o.drive == dmin_q))
  `ASSERT_IMP(a_backcalc_cause, clk_i, rst_ni, ctl.ld_num, clamped_q && (ki_q != 0))

endmodule
`default_nettype wire
